// ===== design/ap2cig_pkg.sv =====
package ap2cig_pkg;

	localparam int unsigned OP_LENGTH_W = 28;

	localparam logic [1:0] MOVE_MATCH  = 2'd0;
	localparam logic [1:0] MOVE_BRANCH = 2'd1;
	localparam logic [1:0] MOVE_STICK  = 2'd2;
	localparam logic [1:0] MOVE_DEL    = 2'd3;

	localparam logic [2:0] KIND_EQ   = 3'd0;
	localparam logic [2:0] KIND_X    = 3'd1;
	localparam logic [2:0] KIND_INS  = 3'd2;
	localparam logic [2:0] KIND_SOFT = 3'd3;
	localparam logic [2:0] KIND_DEL  = 3'd4;
	localparam logic [2:0] KIND_NONE = 3'd5;

	typedef struct packed {
		logic [1:0] move;
		logic [7:0] template_base;
		logic [7:0] read_base;
		logic       path_end;
	} move_item_t;

	typedef struct packed {
		logic                   op_last;
		logic [OP_LENGTH_W-1:0] op_length;
		logic [2:0]             op_kind;
	} cigar_op_t;

endpackage

// ===== design/alignment_path_to_cigar_unit.sv =====
// Alignment path to CIGAR encoder. Each slave transfer carries one alignment move and the
// two bases at the current positions; tlast marks the final move of a path. Master transfers
// carry CIGAR operations, tlast set on the last one of the path. One move is accepted per
// cycle: a move is held in an input register, classified and merged into the open run, and
// its zero, one or two operations enter an eight-entry output queue at the next clock edge.
// tready drops unless the queue has room for two operations of the move in the input
// register and two of a new one, so moves that emit two operations each are paced by the
// single master port.
module alignment_path_to_cigar_unit #(
	parameter int unsigned RUN_LENGTH_BITS = 28
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // move[1:0], template_base[9:2], read_base[17:10], zero
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // op_kind[2:0], op_length[30:3], zero
	output logic        m_tlast
);
	import ap2cig_pkg::*;

	localparam int unsigned DEPTH = 8;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam logic [RUN_LENGTH_BITS-1:0] RUN_MAX = '1;

	logic                       valid_s1;
	move_item_t                 item_s1;
	logic                       started_q;
	logic [2:0]                 run_kind_q;
	logic [RUN_LENGTH_BITS-1:0] run_len_q;

	cigar_op_t                  fifo_q [DEPTH];
	logic [PTR_W-1:0]           wr_ptr_q;
	logic [PTR_W-1:0]           rd_ptr_q;
	logic [PTR_W:0]             count_q;

	logic                       s_xfer;
	logic                       m_xfer;
	logic                       counts;
	logic [2:0]                 kind;
	logic                       emit_run;
	logic [2:0]                 new_kind;
	logic [RUN_LENGTH_BITS-1:0] new_len;
	logic [RUN_LENGTH_BITS-1:0] base_len;
	cigar_op_t                  res0;
	cigar_op_t                  res1;
	logic [1:0]                 n_res;
	logic [PTR_W+1:0]           need;

	function automatic logic [OP_LENGTH_W-1:0] to_op_len(input logic [RUN_LENGTH_BITS-1:0] v);
		logic [31:0] ext;
		ext = 32'(v);
		return ext[OP_LENGTH_W-1:0];
	endfunction

	assign s_xfer = s_tvalid && s_tready;
	assign m_xfer = m_tvalid && m_tready;
	assign need = (PTR_W+2)'(count_q) + (valid_s1 ? (PTR_W+2)'(2) : '0);
	assign s_tready = need <= (PTR_W+2)'(DEPTH - 2);

	always_comb begin
		counts = 1'b1;
		kind = KIND_NONE;
		case (item_s1.move) inside
			MOVE_MATCH: kind = (item_s1.template_base == item_s1.read_base) ? KIND_EQ : KIND_X;
			MOVE_BRANCH, MOVE_STICK: kind = started_q ? KIND_INS : KIND_SOFT;
			default: begin
				kind = KIND_DEL;
				counts = started_q;
			end
		endcase
		emit_run = counts && (kind != run_kind_q) && (run_kind_q != KIND_NONE);
		new_kind = run_kind_q;
		new_len = run_len_q;
		if (counts) begin
			base_len = (kind != run_kind_q) ? '0 : run_len_q;
			new_kind = kind;
			new_len = (base_len != RUN_MAX) ? base_len + 1'b1 : base_len;
		end else begin
			base_len = run_len_q;
		end
		res1.op_kind = new_kind;
		res1.op_length = to_op_len(new_len);
		res1.op_last = 1'b1;
		if (emit_run) begin
			res0.op_kind = run_kind_q;
			res0.op_length = to_op_len(run_len_q);
			res0.op_last = 1'b0;
		end else begin
			res0 = res1;
		end
		n_res = 2'(emit_run) + 2'(item_s1.path_end);
		if (!valid_s1) begin
			n_res = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			item_s1.move <= s_tdata[1:0];
			item_s1.template_base <= s_tdata[9:2];
			item_s1.read_base <= s_tdata[17:10];
			item_s1.path_end <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			run_kind_q <= KIND_NONE;
			run_len_q <= '0;
		end else if (valid_s1) begin
			if (item_s1.path_end) begin
				started_q <= 1'b0;
				run_kind_q <= KIND_NONE;
				run_len_q <= '0;
			end else begin
				started_q <= started_q || (item_s1.move == MOVE_MATCH);
				run_kind_q <= new_kind;
				run_len_q <= new_len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (n_res == 2'd2) begin
			fifo_q[wr_ptr_q + 1'b1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			if (m_xfer) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(n_res) - (PTR_W+1)'(m_xfer);
		end
	end

	assign m_tvalid = count_q != '0;
	assign m_tdata = {1'b0, fifo_q[rd_ptr_q].op_length, fifo_q[rd_ptr_q].op_kind};
	assign m_tlast = fifo_q[rd_ptr_q].op_last;

endmodule

// ===== dv/tb_alignment_path_to_cigar_unit.sv =====
`timescale 1ns / 100ps

module tb_alignment_path_to_cigar_unit;
	import ap2cig_pkg::*;

	localparam int unsigned RANDOM_MOVES = 1200;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;  // move[1:0], template_base[9:2], read_base[17:10], zero
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;  // op_kind[2:0], op_length[30:3], zero
	logic        m_tlast;

	move_item_t pending_moves[$];
	cigar_op_t  expected_ops[$];

	logic                   path_started;
	logic [2:0]             open_kind;
	logic [OP_LENGTH_W-1:0] open_length;

	int moves_popped;
	int total_moves;
	int moves_accepted;
	int ops_checked;
	int paths_done;
	int error_count;

	alignment_path_to_cigar_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("%0t timeout", $time);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic add_move(input logic [1:0] mv, input logic [7:0] tb, input logic [7:0] rb,
			input logic last);
		move_item_t m;
		m.move          = mv;
		m.template_base = tb;
		m.read_base     = rb;
		m.path_end      = last;
		pending_moves.insert(pending_moves.size(), m);
	endtask

	function automatic logic [7:0] pick_base();
		logic [7:0] nucleotides [4];
		nucleotides = '{8'h41, 8'h43, 8'h47, 8'h54};
		if ($urandom_range(99) < 75)
			return nucleotides[$urandom_range(3)];
		return 8'($urandom_range(255));
	endfunction

	task automatic emit_op(input logic [2:0] kind, input logic [OP_LENGTH_W-1:0] len,
			input logic last);
		cigar_op_t op;
		op.op_kind   = kind;
		op.op_length = len;
		op.op_last   = last;
		expected_ops.insert(expected_ops.size(), op);
	endtask

	task automatic encode_move(input move_item_t m);
		logic       counts;
		logic [2:0] kind;
		counts = 1'b1;
		kind   = KIND_NONE;
		if (m.move == MOVE_MATCH) begin
			path_started = 1'b1;
			kind = (m.template_base == m.read_base) ? KIND_EQ : KIND_X;
		end else if (m.move == MOVE_BRANCH || m.move == MOVE_STICK) begin
			kind = path_started ? KIND_INS : KIND_SOFT;
		end else if (path_started) begin
			kind = KIND_DEL;
		end else begin
			counts = 1'b0;
		end
		if (counts) begin
			if (kind != open_kind) begin
				if (open_kind != KIND_NONE)
					emit_op(open_kind, open_length, 1'b0);
				open_kind   = kind;
				open_length = '0;
			end
			if (open_length != '1)
				open_length = open_length + 1'b1;
		end
		if (m.path_end) begin
			emit_op(open_kind, open_length, 1'b1);
			path_started = 1'b0;
			open_kind    = KIND_NONE;
			open_length  = '0;
			paths_done++;
		end
	endtask

	task automatic add_random_path();
		int         body;
		int         rep;
		logic [1:0] mv;
		logic [7:0] tb;
		logic [7:0] rb;
		if ($urandom_range(99) < 15) begin
			body = $urandom_range(8, 1);
			for (int i = 0; i < body; i++)
				add_move(2'($urandom_range(3)), 8'($urandom_range(255)),
					8'($urandom_range(255)), i == body - 1);
			return;
		end
		for (int i = $urandom_range(4); i > 0; i--) begin
			if ($urandom_range(9) == 0)
				add_move(MOVE_DEL, pick_base(), pick_base(), 1'b0);
			add_move($urandom_range(1) ? MOVE_BRANCH : MOVE_STICK, pick_base(), pick_base(),
				1'b0);
		end
		add_move(MOVE_MATCH, 8'h41, 8'h41, 1'b0);
		body = $urandom_range(25, 1);
		while (body > 0) begin
			case ($urandom_range(9))
				0, 1:    mv = $urandom_range(1) ? MOVE_BRANCH : MOVE_STICK;
				2, 3:    mv = MOVE_DEL;
				default: mv = MOVE_MATCH;
			endcase
			rep = $urandom_range(4, 1);
			for (int i = 0; i < rep && body > 0; i++) begin
				tb = pick_base();
				rb = ($urandom_range(99) < 80) ? tb : pick_base();
				body--;
				add_move(mv, tb, rb, body == 0);
			end
		end
	endtask

	always @(negedge clk) begin
		logic hold;
		int   send_idle;
		int   recv_idle;
		if (arst_n) begin
			if (moves_accepted < total_moves / 3) begin
				send_idle = 20;
				recv_idle = 58;
			end else if (moves_accepted < 2 * total_moves / 3) begin
				send_idle = 58;
				recv_idle = 20;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			hold = s_tvalid && (moves_popped == moves_accepted);
			if (moves_popped != moves_accepted) begin
				void'(pending_moves.pop_front());
				moves_popped++;
			end
			if (!hold) begin
				if (pending_moves.size() != 0 && $urandom_range(99) >= send_idle) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {6'b0, pending_moves[0].read_base,
						pending_moves[0].template_base, pending_moves[0].move};
					s_tlast  <= pending_moves[0].path_end;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		move_item_t m;
		cigar_op_t  want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				m.move          = s_tdata[1:0];
				m.template_base = s_tdata[9:2];
				m.read_base     = s_tdata[17:10];
				m.path_end      = s_tlast;
				encode_move(m);
				moves_accepted++;
			end
			if (m_tvalid && m_tready) begin
				if (expected_ops.size() == 0) begin
					error_count++;
					$display("%0t unexpected op: kind %0d length %0d last %0b", $time,
						m_tdata[2:0], m_tdata[30:3], m_tlast);
				end else begin
					want = expected_ops.pop_front();
					ops_checked++;
					if (m_tdata[2:0] !== want.op_kind || m_tdata[30:3] !== want.op_length ||
							m_tlast !== want.op_last) begin
						error_count++;
						$display("%0t mismatch: expected kind %0d length %0d last %0b,",
							$time, want.op_kind, want.op_length, want.op_last,
							" got kind %0d length %0d last %0b",
							m_tdata[2:0], m_tdata[30:3], m_tlast);
					end
				end
			end
		end
	end

	initial begin
		int directed;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		m_tready     = 1'b0;
		path_started = 1'b0;
		open_kind    = KIND_NONE;
		open_length  = '0;

		add_move(MOVE_MATCH,  8'h41, 8'h41, 1'b1);
		add_move(MOVE_DEL,    8'hFF, 8'h00, 1'b1);
		add_move(MOVE_BRANCH, 8'hFF, 8'h00, 1'b0);
		add_move(MOVE_STICK,  8'h00, 8'hFF, 1'b0);
		add_move(MOVE_DEL,    8'h12, 8'h34, 1'b0);
		add_move(MOVE_MATCH,  8'h00, 8'h00, 1'b0);
		add_move(MOVE_MATCH,  8'hFF, 8'hFF, 1'b0);
		add_move(MOVE_MATCH,  8'h00, 8'hFF, 1'b0);
		add_move(MOVE_MATCH,  8'hFF, 8'h00, 1'b0);
		add_move(MOVE_BRANCH, 8'h55, 8'hAA, 1'b0);
		add_move(MOVE_STICK,  8'hAA, 8'h55, 1'b0);
		add_move(MOVE_DEL,    8'h00, 8'h00, 1'b0);
		add_move(MOVE_DEL,    8'hFF, 8'hFF, 1'b1);
		add_move(MOVE_STICK,  8'h47, 8'h54, 1'b1);
		add_move(MOVE_MATCH,  8'hAA, 8'hAA, 1'b0);
		add_move(MOVE_BRANCH, 8'h43, 8'h43, 1'b1);
		add_move(MOVE_MATCH,  8'h01, 8'h02, 1'b0);
		add_move(MOVE_DEL,    8'h80, 8'h7F, 1'b1);
		directed = pending_moves.size();
		while (pending_moves.size() < directed + RANDOM_MOVES)
			add_random_path();
		total_moves = pending_moves.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_moves.size() != 0 || expected_ops.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d moves over %0d paths (%0d directed), checked %0d CIGAR operations",
			moves_accepted, paths_done, directed, ops_checked);
		$display("Sender and receiver stalls swapped mid-run, last third at full rate");
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors", error_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
